// ===== hw/rtl/qcsr_pkg.sv =====
// Shared types, constants and frame builder for the quadrature count reporter.
package qcsr_pkg;

  localparam int DataBytes  = 4;
  localparam int FrameBytes = DataBytes + 1;
  localparam int FrameBits  = FrameBytes * 8;
  localparam int BitCntW    = $clog2(FrameBits + 1);
  localparam int PosW       = 32;
  localparam int TimeoutW   = 16;

  localparam logic [TimeoutW-1:0] TimeoutReset = TimeoutW'(51);
  localparam logic [BitCntW-1:0]  FrameBitsLast = BitCntW'(FrameBits);

  typedef enum logic [2:0] {
    CMD_HALL_A   = 3'd0,
    CMD_HALL_B   = 3'd1,
    CMD_CLK_FALL = 3'd2,
    CMD_CLK_RISE = 3'd3,
    CMD_TICK     = 3'd4
  } cmd_e;

  typedef struct packed {
    logic       fire;
    logic [2:0] cmd;
    logic       level_a;
    logic       level_b;
  } event_t;

  // Data bytes LSB first, sign extended past the fourth, then the checksum byte.
  function automatic logic [FrameBits-1:0] build_frame(logic [PosW-1:0] pos);
    logic [63:0]          ext;
    logic [7:0]           sum;
    logic [FrameBits-1:0] frame;
    ext   = {{32{pos[PosW-1]}}, pos};
    sum   = '0;
    frame = '0;
    for (int i = 0; i < DataBytes; i++) begin
      frame[8*i +: 8] = ext[8*i +: 8];
      sum             = sum + ext[8*i +: 8];
    end
    frame[8*DataBytes +: 8] = sum;
    return frame;
  endfunction

endpackage

// ===== hw/rtl/qcsr_position.sv =====
// Wrapping signed position counter driven by Hall edge events.
module qcsr_position (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  qcsr_pkg::event_t                  ev_i,
  output logic signed [qcsr_pkg::PosW-1:0]  pos_o
);

  logic signed [qcsr_pkg::PosW-1:0] pos_q, pos_d;

  always_comb begin
    pos_d = pos_q;
    if (ev_i.fire) begin
      case (ev_i.cmd)
        qcsr_pkg::CMD_HALL_A: begin
          pos_d = (ev_i.level_a != ev_i.level_b) ? pos_q + 32'sd1 : pos_q - 32'sd1;
        end
        qcsr_pkg::CMD_HALL_B: begin
          pos_d = (ev_i.level_a == ev_i.level_b) ? pos_q + 32'sd1 : pos_q - 32'sd1;
        end
        default: pos_d = pos_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== hw/rtl/qcsr_serializer.sv =====
// Frame latch, bit serializer and tick timeout for the serial readout.
module qcsr_serializer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qcsr_pkg::event_t                    ev_i,
  input  logic [qcsr_pkg::PosW-1:0]           pos_i,
  input  logic [qcsr_pkg::TimeoutW-1:0]       timeout_i,
  output logic                                tx_o,
  output logic                                busy_o
);

  logic                              busy_q, busy_d;
  logic                              tx_q, tx_d;
  logic [qcsr_pkg::FrameBits-1:0]    frame_q, frame_d;
  logic [qcsr_pkg::BitCntW-1:0]      bit_cnt_q, bit_cnt_d;
  logic [qcsr_pkg::TimeoutW-1:0]     tick_q, tick_d;
  logic [qcsr_pkg::TimeoutW-1:0]     tick_inc;

  assign tick_inc = tick_q + qcsr_pkg::TimeoutW'(1);

  always_comb begin
    busy_d    = busy_q;
    tx_d      = tx_q;
    frame_d   = frame_q;
    bit_cnt_d = bit_cnt_q;
    tick_d    = tick_q;
    if (ev_i.fire) begin
      case (ev_i.cmd)
        qcsr_pkg::CMD_CLK_FALL: begin
          if (!busy_q) begin
            frame_d   = qcsr_pkg::build_frame(pos_i);
            bit_cnt_d = '0;
            tick_d    = '0;
            tx_d      = 1'b0;
            busy_d    = 1'b1;
          end
        end
        qcsr_pkg::CMD_CLK_RISE: begin
          if (busy_q) begin
            if (bit_cnt_q == qcsr_pkg::FrameBitsLast) begin
              busy_d = 1'b0;
              tick_d = '0;
              tx_d   = 1'b1;
            end else begin
              tx_d      = frame_q[0];
              frame_d   = frame_q >> 1;
              bit_cnt_d = bit_cnt_q + qcsr_pkg::BitCntW'(1);
            end
          end
        end
        qcsr_pkg::CMD_TICK: begin
          if (busy_q) begin
            if (tick_inc >= timeout_i) begin
              busy_d = 1'b0;
              tick_d = '0;
              tx_d   = 1'b1;
            end else begin
              tick_d = tick_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      tx_q      <= 1'b1;
      bit_cnt_q <= '0;
      tick_q    <= '0;
    end else begin
      busy_q    <= busy_d;
      tx_q      <= tx_d;
      bit_cnt_q <= bit_cnt_d;
      tick_q    <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign tx_o   = tx_q;
  assign busy_o = busy_q;

endmodule

// ===== hw/rtl/quadrature_count_serial_reporter.sv =====
// Top level: quadrature position counter with a clocked serial frame readout.
//
// Input channel: in_valid_i / in_stall_o carry one event (cmd_i, level_a_i,
// level_b_i) per transaction. Commands: Hall A edge, Hall B edge, clock fall,
// clock rise, tick; other codes change nothing but still give a result.
// Output channel: out_valid_o / out_stall_i carry one result per event:
// the line level, the busy flag and the signed position after that event.
// Config channel: cfg_valid_i / cfg_ready_o write the 16-bit tick timeout;
// cfg_ready_o is always high. Write it only while the block is idle.
// The result passes through the input register, then the state registers,
// which are the result register.
// Throughput: one event per cycle while the result is not stalled; set by the state update.
// When the receiver stalls, the result holds and the input register keeps one
// more transaction; in_stall_o is high while that register is full and the
// result is stalled. No transaction is lost.
// Reset: position zero, idle, line high, timeout 51, both stages empty.
module quadrature_count_serial_reporter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          cmd_i,
  input  logic                                level_a_i,
  input  logic                                level_b_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                tx_level_o,
  output logic                                busy_res_o,
  output logic signed [qcsr_pkg::PosW-1:0]    position_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qcsr_pkg::TimeoutW-1:0]       cfg_wdata_i
);

  logic                          s1_valid_q;
  logic [2:0]                    s1_cmd_q;
  logic                          s1_a_q;
  logic                          s1_b_q;
  logic                          out_valid_q, out_valid_d;
  logic [qcsr_pkg::TimeoutW-1:0] timeout_q;
  logic                          res_ready;
  logic                          s1_ready;
  logic                          fire;
  qcsr_pkg::event_t              ev;
  logic signed [qcsr_pkg::PosW-1:0] pos;

  assign res_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || res_ready;
  assign fire       = s1_valid_q && res_ready;
  assign in_stall_o = !s1_ready;
  assign cfg_ready_o = 1'b1;

  assign ev.fire    = fire;
  assign ev.cmd     = s1_cmd_q;
  assign ev.level_a = s1_a_q;
  assign ev.level_b = s1_b_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= qcsr_pkg::TimeoutReset;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_cmd_q <= cmd_i;
      s1_a_q   <= level_a_i;
      s1_b_q   <= level_b_i;
    end
  end

  qcsr_position u_position (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ev_i   (ev),
    .pos_o  (pos)
  );

  qcsr_serializer u_serializer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ev_i      (ev),
    .pos_i     (pos),
    .timeout_i (timeout_q),
    .tx_o      (tx_level_o),
    .busy_o    (busy_res_o)
  );

  assign out_valid_o = out_valid_q;
  assign position_o  = pos;

endmodule

// ===== hw/rtl/qcsr_checker.sv =====
// Port-level assertions for the quadrature count reporter, bound to the top.
module qcsr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             tx_level_o,
  input logic                             busy_res_o,
  input logic signed [qcsr_pkg::PosW-1:0] position_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The line idles high whenever a result is offered and no transfer is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> tx_level_o)
    else $error("line low while idle");

  // Back-to-back results come from single events: position moves by at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) ##1 out_valid_o |->
      (position_o == $past(position_o)) ||
      (position_o == $past(position_o) + 32'sd1) ||
      (position_o == $past(position_o) - 32'sd1))
    else $error("position jumped between consecutive results");

endmodule

bind quadrature_count_serial_reporter qcsr_checker u_qcsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .tx_level_o  (tx_level_o),
  .busy_res_o  (busy_res_o),
  .position_o  (position_o)
);
